/* src/sqe_pkg.sv */
// Shared constants, request codes and status codes of the sorted store quantile engine.
package sqe_pkg;
  localparam int MAX_SAMPLES = 256;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int DATA_W      = 32;
  localparam int PROB_W      = 17;
  localparam int FRAC_W      = 16;
  localparam int POS_W       = PROB_W + ADDR_W;
  localparam int DIFF_W      = DATA_W + 1;
  localparam int PROD_W      = DIFF_W + FRAC_W + 1;

  localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(65536);
  localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_SAMPLES);

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;
endpackage

/* src/sqe_if.sv */
// Request and result channel interfaces of the sorted store quantile engine.
interface sqe_in_if;
  import sqe_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic signed [DATA_W-1:0] sample;
  logic [PROB_W-1:0]        prob;
  modport source (output valid, req_type, sample, prob, input ready);
  modport sink (input valid, req_type, sample, prob, output ready);
endinterface

interface sqe_out_if;
  import sqe_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic [1:0]               status;
  logic [CNT_W-1:0]         count;
  modport source (output valid, value, status, count, input ready);
  modport sink (input valid, value, status, count, output ready);
endinterface

/* src/sorted_store_quantile_engine_top.sv */
// Top level of the sorted store quantile engine: sample memory, insert walk and query datapath.
// The engine holds up to MAX_SAMPLES signed samples in ascending order in one
// single-port-read, single-port-write memory with a registered read.
// A load request walks down from the top of the store, moving each larger
// entry up by one place per cycle. A query works in order through the
// position multiply, two memory reads for the bracketing entries, the
// difference multiply and the final add, then the result hand-off; a query
// whose position lands on the last entry skips the second read and the
// interpolation. Clear, empty queries, dropped loads, loads into an empty
// store and unused codes go straight to the result hand-off. One request
// is worked at a time; a new request is accepted while the previous result
// still waits at the output register. The memory needs no clearing pass:
// only entries below the sample count are ever used.
module sorted_store_quantile_engine_top (
  input logic clk,
  input logic rst_n,
  sqe_in_if.sink    in_ch,
  sqe_out_if.source out_ch
);
  import sqe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_INS, S_INS_LAST, S_QRD0, S_QRD1, S_QTOP, S_QDIF, S_QADD, S_FIN
  } state_t;

  state_t state_r;

  // sample memory: one write and one registered read per cycle
  logic signed [DATA_W-1:0] mem [MAX_SAMPLES];
  logic signed [DATA_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic signed [DATA_W-1:0] wr_data;

  logic [CNT_W-1:0]         count_r;
  logic [ADDR_W-1:0]        last;
  logic [ADDR_W-1:0]        k_r;
  logic signed [DATA_W-1:0] v_r;
  logic [POS_W-1:0]         pos_r;
  logic [ADDR_W-1:0]        j;
  logic [FRAC_W-1:0]        h;
  logic signed [DATA_W-1:0] lo_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] sum;
  logic [PROB_W-1:0]        prob_sat;
  logic                     in_fire;
  logic                     top_hit;
  logic                     shift_up;

  logic signed [DATA_W-1:0] res_value_r;
  status_t                  res_status_r;
  logic [CNT_W-1:0]         res_count_r;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic [1:0]               out_status_r;
  logic [CNT_W-1:0]         out_count_r;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.status = out_status_r;
  assign out_ch.count  = out_count_r;

  assign last     = ADDR_W'(count_r - CNT_W'(1));
  assign j        = pos_r[FRAC_W +: ADDR_W];
  assign h        = pos_r[FRAC_W-1:0];
  assign top_hit  = (j >= last);
  assign prob_sat = (in_ch.prob > ONE_Q16) ? ONE_Q16 : in_ch.prob;
  // entry under the walk is larger than the new sample: move it up
  assign shift_up = (rd_data_r > v_r);
  assign diff     = DIFF_W'(rd_data_r) - DIFF_W'(lo_r);
  // arithmetic shift floors the interpolation step
  assign sum      = PROD_W'(lo_r) + (prod_r >>> FRAC_W);

  // memory port control
  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = v_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_ch.req_type == REQ_LOAD && count_r != CNT_MAX) begin
          rd_addr = last;
          if (count_r == '0) begin
            wr_en   = 1'b1;
            wr_data = in_ch.sample;
          end
        end
      end
      S_INS: begin
        rd_addr = k_r - ADDR_W'(1);
        wr_en   = 1'b1;
        wr_addr = k_r + ADDR_W'(1);
        wr_data = shift_up ? rd_data_r : v_r;
      end
      S_INS_LAST: begin
        wr_en = 1'b1;
      end
      S_QRD0:  rd_addr = top_hit ? last : j;
      S_QRD1:  rd_addr = j + ADDR_W'(1);
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the shown result once taken, unless a new one replaces it
      if (out_valid_r && out_ch.ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            res_value_r  <= '0;
            res_status_r <= ST_OK;
            res_count_r  <= count_r;
            v_r          <= in_ch.sample;
            k_r          <= last;
            pos_r        <= prob_sat * last;
            state_r      <= S_FIN;
            unique case (in_ch.req_type)
              REQ_LOAD: begin
                if (count_r == CNT_MAX) begin
                  res_status_r <= ST_FULL;
                end else if (count_r == '0) begin
                  count_r     <= CNT_W'(1);
                  res_count_r <= CNT_W'(1);
                end else begin
                  state_r <= S_INS;
                end
              end
              REQ_QUERY: begin
                if (count_r == '0) begin
                  res_status_r <= ST_EMPTY;
                end else begin
                  state_r <= S_QRD0;
                end
              end
              REQ_CLEAR: begin
                count_r     <= '0;
                res_count_r <= '0;
              end
              default: ;
            endcase
          end
        end
        S_INS: begin
          if (!shift_up) begin
            count_r     <= count_r + CNT_W'(1);
            res_count_r <= count_r + CNT_W'(1);
            state_r     <= S_FIN;
          end else if (k_r == '0) begin
            state_r <= S_INS_LAST;
          end else begin
            k_r <= k_r - ADDR_W'(1);
          end
        end
        S_INS_LAST: begin
          count_r     <= count_r + CNT_W'(1);
          res_count_r <= count_r + CNT_W'(1);
          state_r     <= S_FIN;
        end
        S_QRD0: state_r <= top_hit ? S_QTOP : S_QRD1;
        S_QRD1: begin
          lo_r    <= rd_data_r;
          state_r <= S_QDIF;
        end
        S_QTOP: begin
          res_value_r <= rd_data_r;
          state_r     <= S_FIN;
        end
        S_QDIF: begin
          prod_r  <= diff * $signed({1'b0, h});
          state_r <= S_QADD;
        end
        S_QADD: begin
          res_value_r <= sum[DATA_W-1:0];
          state_r     <= S_FIN;
        end
        S_FIN: begin
          // hold the result until the output register is free
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_value_r  <= res_value_r;
            out_status_r <= res_status_r;
            out_count_r  <= res_count_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("sample count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FULL) |-> (out_count_r == CNT_MAX))
    else $error("full status with store not full");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_EMPTY) |-> (out_count_r == '0 && out_value_r == '0))
    else $error("empty status with nonzero count or value");

  a_insert_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_LAST) |=> (state_r == S_FIN && count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert at bottom did not grow the store");
endmodule
